// ===== rtl/dqd_pkg.sv =====
// ----------------------------------------------------------------------------
// dqd_pkg
// Types and constants shared by the deque with delete-by-value.
// ----------------------------------------------------------------------------
`default_nettype none

package dqd_pkg;

  localparam int Depth  = 16;
  localparam int DataW  = 32;
  localparam int CountW = $clog2(Depth + 1);

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [CountW-1:0]       count_t;

  typedef enum logic [1:0] {
    CMD_APPEND  = 2'd0,
    CMD_PREPEND = 2'd1,
    CMD_DEQUEUE = 2'd2,
    CMD_DELETE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e  cmd;
    data_t value;
  } in_t;

  typedef struct packed {
    status_e status;
    data_t   value_out;
    count_t  length;
  } out_t;

  typedef struct packed {
    logic   en;
    cmd_e   cmd;
    data_t  value;
    count_t count;
    logic   full;
    logic   empty;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/dqd_cell.sv =====
// ----------------------------------------------------------------------------
// dqd_cell
// One queue slot: holds the entry at a fixed offset from the head, compares
// it with the search value and shifts toward either neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module dqd_cell #(
  parameter int Idx = 0
) (
  input  wire logic                clk_i,
  input  wire dqd_pkg::cell_ctrl_t ctrl_i,
  input  wire dqd_pkg::data_t      left_val_i,
  input  wire dqd_pkg::data_t      right_val_i,
  input  wire logic                hit_i,
  output dqd_pkg::data_t           val_o,
  output logic                     hit_o
);

  dqd_pkg::data_t val_q;
  dqd_pkg::data_t val_d;
  logic           occupied;
  logic           at_tail;

  assign occupied = dqd_pkg::count_t'(Idx) < ctrl_i.count;
  assign at_tail  = dqd_pkg::count_t'(Idx) == ctrl_i.count;
  assign hit_o    = hit_i | (occupied && (val_q == ctrl_i.value));
  assign val_o    = val_q;

  always_comb begin
    val_d = val_q;
    unique case (ctrl_i.cmd)
      dqd_pkg::CMD_APPEND: begin
        if (!ctrl_i.full && at_tail) val_d = ctrl_i.value;
      end
      dqd_pkg::CMD_PREPEND: begin
        if (!ctrl_i.full) val_d = (Idx == 0) ? ctrl_i.value : left_val_i;
      end
      dqd_pkg::CMD_DEQUEUE: begin
        if (!ctrl_i.empty) val_d = right_val_i;
      end
      dqd_pkg::CMD_DELETE: begin
        if (hit_o) val_d = right_val_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) val_q <= val_d;
  end

endmodule

`default_nettype wire

// ===== rtl/deque_with_delete_by_value.sv =====
// ----------------------------------------------------------------------------
// deque_with_delete_by_value
// Bounded double-ended queue of signed 32-bit values with delete by value.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one request:
// append at tail, prepend at head, dequeue head, or delete the first entry
// from the head that equals the value, closing the gap. Each request gives
// one transaction on the output channel (out_valid_o / out_stall_i /
// out_data_o) with a status, the dequeued value and the length afterward.
// Slots sit in a row of cells ordered from the head; every cell compares its
// entry at once and shifts toward a neighbor, so any request completes in the
// clock edge that accepts it. The registered result appears in the cycle after
// acceptance; requests are taken one per cycle while in_stall_o is low. It
// rises only while a result waits in the output register and out_stall_i is
// high; the result then holds. Reset empties the queue and drops a pending
// result; slot contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_delete_by_value (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire dqd_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output dqd_pkg::out_t     out_data_o
);

  localparam int Depth = dqd_pkg::Depth;

  dqd_pkg::cell_ctrl_t ctrl;
  dqd_pkg::data_t      vals [Depth];
  logic [Depth-1:0]    hits;
  dqd_pkg::count_t     count_q, count_d;
  logic                out_valid_q, out_valid_d;
  dqd_pkg::out_t       out_q, out_d;
  logic                in_acc;
  logic                full, empty;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign full       = count_q == dqd_pkg::count_t'(Depth);
  assign empty      = count_q == '0;

  assign ctrl.en    = in_acc;
  assign ctrl.cmd   = in_data_i.cmd;
  assign ctrl.value = in_data_i.value;
  assign ctrl.count = count_q;
  assign ctrl.full  = full;
  assign ctrl.empty = empty;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    dqd_pkg::data_t left_val;
    dqd_pkg::data_t right_val;
    logic           hit_in;

    if (k == 0) begin : g_head
      assign left_val = '0;
      assign hit_in   = 1'b0;
    end else begin : g_body
      assign left_val = vals[k-1];
      assign hit_in   = hits[k-1];
    end

    if (k == Depth - 1) begin : g_tail
      assign right_val = vals[k];
    end else begin : g_mid
      assign right_val = vals[k+1];
    end

    dqd_cell #(
      .Idx(k)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .hit_i      (hit_in),
      .val_o      (vals[k]),
      .hit_o      (hits[k])
    );
  end

  always_comb begin
    count_d         = count_q;
    out_d.status    = dqd_pkg::ST_OK;
    out_d.value_out = '0;
    unique case (in_data_i.cmd)
      dqd_pkg::CMD_APPEND, dqd_pkg::CMD_PREPEND: begin
        if (full) out_d.status = dqd_pkg::ST_FULL;
        else      count_d = count_q + dqd_pkg::count_t'(1);
      end
      dqd_pkg::CMD_DEQUEUE: begin
        if (empty) begin
          out_d.status = dqd_pkg::ST_MISS;
        end else begin
          out_d.value_out = vals[0];
          count_d         = count_q - dqd_pkg::count_t'(1);
        end
      end
      dqd_pkg::CMD_DELETE: begin
        if (!hits[Depth-1]) out_d.status = dqd_pkg::ST_MISS;
        else                count_d = count_q - dqd_pkg::count_t'(1);
      end
      default: out_d.status = dqd_pkg::ST_OK;
    endcase
    out_d.length = count_d;
  end

  assign out_valid_d = in_acc | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/dqd_checker.sv =====
// ----------------------------------------------------------------------------
// dqd_checker
// Port-level checks for the deque with delete-by-value, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dqd_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire dqd_pkg::out_t out_data_o
);

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a pending result");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted transaction gave no result");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.length <= dqd_pkg::count_t'(dqd_pkg::Depth)))
    else $error("length beyond depth");

  a_value_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != dqd_pkg::ST_OK)) |->
      (out_data_o.value_out == '0))
    else $error("nonzero value on error status");

endmodule

bind deque_with_delete_by_value dqd_checker u_dqd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
